@@ sv/lsp_pkg.sv @@
// Shared types, constants and codes for the LED strip pixel symbol encoder.
package lsp_pkg;

    localparam int CHAN_W   = 8;
    localparam int TICK_W   = 15;
    localparam int LATCH_W  = 16;
    localparam int WORD_W   = 4 * CHAN_W;
    localparam int BITCNT_W = $clog2(WORD_W);
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAN_W-1:0]   BRIGHT_FULL = 8'd255;
    localparam logic [2*CHAN_W-1:0] ROUND_OFS   = 16'd127;

    // Index of the final bit of a pixel, three or four channels
    localparam logic [BITCNT_W-1:0] LAST_BIT_RGB  = 5'd23;
    localparam logic [BITCNT_W-1:0] LAST_BIT_RGBW = 5'd31;

    localparam logic [TICK_W-1:0] TICK_MAX = 15'h7FFF;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_RGBW_MODE  = 3'd1,
        REG_ZERO_HIGH  = 3'd2,
        REG_ZERO_LOW   = 3'd3,
        REG_ONE_HIGH   = 3'd4,
        REG_ONE_LOW    = 3'd5,
        REG_LATCH      = 3'd6
    } t_reg_idx;

    // Serialiser states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BITS,
        BK_LATCH
    } t_back_state;

    // One classified pixel waiting in the queue
    typedef struct packed {
        logic [WORD_W-1:0] word;   // scaled G,R,B,W, MSB first
        logic              rgbw;
        logic              last;
    } t_entry;

    // Pulse timings handed to the serialiser
    typedef struct packed {
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  zero_low;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  one_low;
        logic [LATCH_W-1:0] latch;
    } t_timing;

    // One outgoing symbol
    typedef struct packed {
        logic              level_first;
        logic [TICK_W-1:0] ticks_first;
        logic              level_second;
        logic [TICK_W-1:0] ticks_second;
        logic              is_reset;
        logic              run_end;
    } t_symbol;

endpackage

@@ sv/lsp_pixel_if.sv @@
// Pixel request channel.
interface lsp_pixel_if import lsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;
    logic              last_pixel;

    modport source (output valid, red, green, blue, white, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, white, last_pixel, output ready);
endinterface

@@ sv/lsp_symbol_if.sv @@
// Pulse symbol request channel.
interface lsp_symbol_if import lsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              level_first;
    logic [TICK_W-1:0] ticks_first;
    logic              level_second;
    logic [TICK_W-1:0] ticks_second;
    logic              is_reset;
    logic              run_end;

    modport source (output valid, level_first, ticks_first, level_second, ticks_second,
                    is_reset, run_end, input ready);
    modport sink   (input valid, level_first, ticks_first, level_second, ticks_second,
                    is_reset, run_end, output ready);
endinterface

@@ sv/led_strip_pixel_symbol_encoder.sv @@
// Top level of the LED strip pixel symbol encoder: registers, front, queue, back.
//
// Usage:
//   i_pix takes one pixel request (red, green, blue, white, last_pixel) per
//   valid/ready handshake. o_sym gives pulse symbols, one per handshake, in the
//   order green, red, blue (then white in four-channel mode), MSB first, and a
//   low latch symbol after a pixel flagged last_pixel. run_end marks the final
//   symbol of each pixel.
//   The APB port sets brightness, mode and tick timings; write only while idle.
//   A request is written into the queue, and its first symbol then into the
//   back end's output register before it appears on o_sym.
//   Throughput: one symbol per cycle from the serialiser in the back end while
//   o_sym is ready, so a pixel gives 24 bit symbols (32 in four-channel mode),
//   plus one latch symbol after a last pixel. The next pixel's bits follow with no gap when it is queued.
//   The front accepts a new pixel while the back is busy until the queue
//   (FIFO_DEPTH entries) is full.
//   Reset: synchronous, active low; empties queue and output, loads default
//   timings. A stalled o_sym holds its symbol; the back halts and the queue
//   fills, after which i_pix.ready drops.
module led_strip_pixel_symbol_encoder import lsp_pkg::*; #(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lsp_pixel_if.sink          i_pix,
    lsp_symbol_if.source       o_sym,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CHAN_W-1:0]  r_brightness;
    logic               r_rgbw_mode;
    logic [TICK_W-1:0]  r_zero_high;
    logic [TICK_W-1:0]  r_zero_low;
    logic [TICK_W-1:0]  r_one_high;
    logic [TICK_W-1:0]  r_one_low;
    logic [LATCH_W-1:0] r_latch;

    logic     cfg_wr;
    t_reg_idx reg_idx;
    t_timing  timing;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;
    t_entry   q_in;
    t_entry   q_head;

    // Register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= 8'd255;
            r_rgbw_mode  <= 1'b0;
            r_zero_high  <= 15'd3;
            r_zero_low   <= 15'd9;
            r_one_high   <= 15'd9;
            r_one_low    <= 15'd3;
            r_latch      <= 16'd800;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BRIGHTNESS: r_brightness <= pwdata[CHAN_W-1:0];
                REG_RGBW_MODE:  r_rgbw_mode  <= pwdata[0];
                REG_ZERO_HIGH:  r_zero_high  <= pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   r_zero_low   <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   r_one_high   <= pwdata[TICK_W-1:0];
                REG_ONE_LOW:    r_one_low    <= pwdata[TICK_W-1:0];
                REG_LATCH:      r_latch      <= pwdata[LATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_BRIGHTNESS: prdata = DATA_W'(r_brightness);
            REG_RGBW_MODE:  prdata = DATA_W'(r_rgbw_mode);
            REG_ZERO_HIGH:  prdata = DATA_W'(r_zero_high);
            REG_ZERO_LOW:   prdata = DATA_W'(r_zero_low);
            REG_ONE_HIGH:   prdata = DATA_W'(r_one_high);
            REG_ONE_LOW:    prdata = DATA_W'(r_one_low);
            REG_LATCH:      prdata = DATA_W'(r_latch);
            default:        prdata = '0;
        endcase
    end

    assign timing.zero_high = r_zero_high;
    assign timing.zero_low  = r_zero_low;
    assign timing.one_high  = r_one_high;
    assign timing.one_low   = r_one_low;
    assign timing.latch     = r_latch;

    lsp_front u_front (
        .i_pix        (i_pix),
        .i_brightness (r_brightness),
        .i_rgbw_mode  (r_rgbw_mode),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    lsp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    lsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timing  (timing),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_sym     (o_sym)
    );

    // A latch symbol always closes its pixel's run and is low throughout
    a_reset_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.valid && o_sym.is_reset |-> o_sym.run_end && !o_sym.level_first
                                          && !o_sym.level_second)
        else $error("latch symbol malformed");

    // Bit symbols go high then low
    a_bit_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.valid && !o_sym.is_reset |-> o_sym.level_first && !o_sym.level_second)
        else $error("bit symbol levels wrong");

    // Queue is never popped when empty
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

@@ sv/lsp_front.sv @@
// Front end: accepts pixels, scales channels by brightness, queues the bit word.
module lsp_front import lsp_pkg::*; (
    lsp_pixel_if.sink         i_pix,
    input  logic [CHAN_W-1:0] i_brightness,
    input  logic              i_rgbw_mode,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    // (v*br + 127) / 255 via reciprocal: (x + 1 + (x >> 8)) >> 8, exact for x < 65535
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] v,
                                                     input logic [CHAN_W-1:0] br);
        logic [2*CHAN_W-1:0] x;
        logic [2*CHAN_W:0]   y;
        x = (2*CHAN_W)'(v) * (2*CHAN_W)'(br) + ROUND_OFS;
        y = {1'b0, x} + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]);
        return y[2*CHAN_W-1:CHAN_W];
    endfunction

    logic bypass;

    assign bypass = (i_brightness == BRIGHT_FULL);

    // Handshake: take a pixel whenever the queue has room
    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    // Classify: channel order green, red, blue, white
    always_comb begin
        if (bypass) begin
            o_entry.word = {i_pix.green, i_pix.red, i_pix.blue, i_pix.white};
        end else begin
            o_entry.word = {scale_chan(i_pix.green, i_brightness),
                            scale_chan(i_pix.red,   i_brightness),
                            scale_chan(i_pix.blue,  i_brightness),
                            scale_chan(i_pix.white, i_brightness)};
        end
        o_entry.rgbw = i_rgbw_mode;
        o_entry.last = i_pix.last_pixel;
    end

endmodule

@@ sv/lsp_fifo.sv @@
// Short queue of classified pixels between front and back.
module lsp_fifo import lsp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

@@ sv/lsp_back.sv @@
// Back end: serialises queued pixels into one pulse symbol per cycle while o_sym is ready.
module lsp_back import lsp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_timing      i_timing,
    input  logic         i_q_valid,
    input  t_entry       i_q_head,
    output logic         o_pop,
    lsp_symbol_if.source o_sym
);

    t_back_state         r_state, n_state;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [BITCNT_W-1:0] r_bit, n_bit;
    logic                r_rgbw, n_rgbw;
    logic                r_last, n_last;
    logic                r_ov, n_ov;
    t_symbol             r_out, n_out;

    logic                advance;
    logic [WORD_W-1:0]   cur_word;
    logic [BITCNT_W-1:0] cur_bit;
    logic                cur_rgbw;
    logic                cur_last;
    logic                bit_end;
    logic [LATCH_W-1:0]  rest;

    // Output register frees when empty or taken
    assign advance = !r_ov || o_sym.ready;

    // Remainder of the latch time, saturated to the tick width
    assign rest = {1'b0, i_timing.latch[LATCH_W-1:1]} + LATCH_W'(i_timing.latch[0]);

    // Bit source: current pixel, or the queue head when starting a new one
    always_comb begin
        if (r_state == BK_BITS) begin
            cur_word = r_word;
            cur_bit  = r_bit;
            cur_rgbw = r_rgbw;
            cur_last = r_last;
        end else begin
            cur_word = i_q_head.word;
            cur_bit  = '0;
            cur_rgbw = i_q_head.rgbw;
            cur_last = i_q_head.last;
        end
        bit_end = (cur_bit == (cur_rgbw ? LAST_BIT_RGBW : LAST_BIT_RGB));
    end

    // Next state and symbol
    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_bit   = r_bit;
        n_rgbw  = r_rgbw;
        n_last  = r_last;
        n_ov    = r_ov;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (advance) begin
            priority if (r_state == BK_LATCH) begin
                n_out.level_first  = 1'b0;
                n_out.ticks_first  = i_timing.latch[LATCH_W-1:1];
                n_out.level_second = 1'b0;
                n_out.ticks_second = rest[LATCH_W-1] ? TICK_MAX : rest[TICK_W-1:0];
                n_out.is_reset     = 1'b1;
                n_out.run_end      = 1'b1;
                n_ov               = 1'b1;
                n_state            = BK_IDLE;
            end else if (r_state == BK_BITS || i_q_valid) begin
                o_pop              = (r_state != BK_BITS);
                n_out.level_first  = 1'b1;
                n_out.ticks_first  = cur_word[WORD_W-1] ? i_timing.one_high
                                                        : i_timing.zero_high;
                n_out.level_second = 1'b0;
                n_out.ticks_second = cur_word[WORD_W-1] ? i_timing.one_low
                                                        : i_timing.zero_low;
                n_out.is_reset     = 1'b0;
                n_out.run_end      = bit_end && !cur_last;
                n_ov               = 1'b1;
                n_word             = {cur_word[WORD_W-2:0], 1'b0};
                n_bit              = cur_bit + 1'b1;
                n_rgbw             = cur_rgbw;
                n_last             = cur_last;
                if (!bit_end) begin
                    n_state = BK_BITS;
                end else if (cur_last) begin
                    n_state = BK_LATCH;
                end else begin
                    n_state = BK_IDLE;
                end
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_bit  <= n_bit;
        r_rgbw <= n_rgbw;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_sym.valid        = r_ov;
    assign o_sym.level_first  = r_out.level_first;
    assign o_sym.ticks_first  = r_out.ticks_first;
    assign o_sym.level_second = r_out.level_second;
    assign o_sym.ticks_second = r_out.ticks_second;
    assign o_sym.is_reset     = r_out.is_reset;
    assign o_sym.run_end      = r_out.run_end;

endmodule
